### src/lae_pkg.sv
package lae_pkg;

  localparam int unsigned ENTRIES     = 256;
  localparam int unsigned ENTRY_W     = 8;
  localparam int unsigned TABLE_DEPTH = (ENTRIES > 256) ? 256 : ENTRIES;
  localparam int unsigned ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int unsigned DATA_W      = 64;
  localparam int unsigned STEP_W      = 7;
  localparam int unsigned CFG_IDX_W   = 2;

  localparam logic [DATA_W-1:0] WINDOW_RESET = 64'd1000000000;
  localparam logic [DATA_W-1:0] DUMP_RESET   = 64'd3000000000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_OVER_MODE = 2'd0,
    CFG_WINDOW    = 2'd1,
    CFG_DUMP      = 2'd2
  } cfg_idx_e;

  typedef enum logic [2:0] {
    AS_ABSENT = 3'd0,
    AS_NEW    = 3'd1,
    AS_ACTIVE = 3'd2,
    AS_ALMOST = 3'd3,
    AS_GONE   = 3'd4
  } alarm_state_e;

  typedef enum logic [1:0] {
    EV_NONE   = 2'd0,
    EV_HIT    = 2'd1,
    EV_UPDATE = 2'd2,
    EV_NORMAL = 2'd3
  } event_e;

  typedef enum logic [1:0] {
    MD_IDLE = 2'd0,
    MD_MUL  = 2'd1,
    MD_DIV  = 2'd2,
    MD_DONE = 2'd3
  } md_phase_e;

  typedef enum logic [2:0] {
    FS_IDLE  = 3'd0,
    FS_PREP  = 3'd1,
    FS_DECAY = 3'd2,
    FS_WAIT  = 3'd3,
    FS_CMP   = 3'd4,
    FS_FIN   = 3'd5
  } fsm_e;

  typedef struct packed {
    alarm_state_e      state;
    logic [DATA_W-1:0] last_time;
    logic [DATA_W-1:0] dump_time;
    logic [DATA_W-1:0] norm_time;
    logic [DATA_W-1:0] value;
    logic [DATA_W-1:0] limit;
    logic [DATA_W-1:0] hold;
  } entry_rec_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    entry_rec_t        rec;
  } tbl_wr_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
  } tbl_rd_t;

endpackage

### src/lae_table.sv
module lae_table
  import lae_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  tbl_rd_t    rd_i,
  output entry_rec_t rd_rec_o,
  input  tbl_wr_t    wr_i
);

  entry_rec_t             mem [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] valid_q;
  entry_rec_t             rd_q;
  logic                   rd_valid_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr] <= wr_i.rec;
    end
    if (rd_i.en) begin
      rd_q <= mem[rd_i.addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (wr_i.en) begin
        valid_q[wr_i.addr] <= 1'b1;
      end
      if (rd_i.en) begin
        rd_valid_q <= valid_q[rd_i.addr];
      end
    end
  end

  // an entry never written reads as absent
  always_comb begin
    rd_rec_o = rd_q;
    if (!rd_valid_q) begin
      rd_rec_o.state = AS_ABSENT;
    end
  end

endmodule

### src/lae_muldiv.sv
module lae_muldiv
  import lae_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [DATA_W-1:0] a_i,
  input  logic [DATA_W-1:0] b_i,
  input  logic [DATA_W-1:0] d_i,
  output logic              done_o,
  output logic [DATA_W-1:0] q_o
);

  md_phase_e             phase_q, phase_d;
  logic [STEP_W-1:0]     cnt_q;
  logic [2*DATA_W-1:0]   acc_q;
  logic [DATA_W-1:0]     rem_q;
  logic [DATA_W-1:0]     a_q;
  logic [DATA_W-1:0]     d_q;
  logic [DATA_W:0]       mul_sum;
  logic [DATA_W:0]       rem_sh;
  logic [DATA_W:0]       rem_sub;
  logic                  rem_ge;

  // one multiply step: add a into the upper half, shift right
  assign mul_sum = {1'b0, acc_q[2*DATA_W-1:DATA_W]} + (acc_q[0] ? {1'b0, a_q} : '0);
  // one restoring divide step
  assign rem_sh  = {rem_q, acc_q[2*DATA_W-1]};
  assign rem_ge  = rem_sh >= {1'b0, d_q};
  assign rem_sub = rem_sh - {1'b0, d_q};

  always_comb begin
    phase_d = phase_q;
    unique case (phase_q)
      MD_IDLE: if (start_i) phase_d = MD_MUL;
      MD_MUL:  if (cnt_q == STEP_W'(DATA_W - 1)) phase_d = MD_DIV;
      MD_DIV:  if (cnt_q == STEP_W'(2 * DATA_W - 1)) phase_d = MD_DONE;
      MD_DONE: phase_d = MD_IDLE;
      default: phase_d = MD_IDLE;
    endcase
  end

  always_comb begin
    done_o = (phase_q == MD_DONE);
    q_o    = acc_q[DATA_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= MD_IDLE;
    end else begin
      phase_q <= phase_d;
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (phase_q)
      MD_IDLE: begin
        acc_q <= {{DATA_W{1'b0}}, b_i};
        a_q   <= a_i;
        d_q   <= d_i;
        rem_q <= '0;
        cnt_q <= '0;
      end
      MD_MUL: begin
        acc_q <= {mul_sum, acc_q[DATA_W-1:1]};
        cnt_q <= (cnt_q == STEP_W'(DATA_W - 1)) ? '0 : cnt_q + 1'b1;
      end
      MD_DIV: begin
        rem_q <= rem_ge ? rem_sub[DATA_W-1:0] : rem_sh[DATA_W-1:0];
        acc_q <= {acc_q[2*DATA_W-2:0], rem_ge};
        cnt_q <= cnt_q + 1'b1;
      end
      default: begin
        cnt_q <= '0;
      end
    endcase
  end

endmodule

### src/limit_alarm_entry_table.sv
// Table of 256 alarm entries driven by merge (cmd 0) and evaluate (cmd 1)
// items; every item gives exactly one result. An item is taken in a single
// transfer and the block stays busy until its result is placed in the output
// register. A merge, and an evaluate of a new, absent or gone entry, pass the
// prep and final states. An evaluate of an active or almost gone entry whose
// elapsed time is zero or beyond the window passes the prep, decay, compare
// and final states. An evaluate that decays the value also waits in the wait
// state on a shared bit-serial unit, 64 multiply steps then 128 divide steps;
// this unit sets the rate. A result still waiting for its transfer holds the
// block in its final state. The next item is taken while the last result
// still waits for its transfer. Configuration writes are always taken.
module limit_alarm_entry_table
  import lae_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [DATA_W-1:0]    cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic                 cmd_i,
  input  logic [ENTRY_W-1:0]   entry_i,
  input  logic [DATA_W-1:0]    now_ns_i,
  input  logic [DATA_W-1:0]    value_i,
  input  logic [DATA_W-1:0]    limit_i,
  input  logic [DATA_W-1:0]    hold_ns_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [ENTRY_W-1:0]   out_entry_o,
  output logic [1:0]           event_res_o,
  output logic [DATA_W-1:0]    report_value_o,
  output logic [DATA_W-1:0]    report_limit_o
);

  fsm_e              state_q, state_d;
  logic              over_q;
  logic [DATA_W-1:0] window_q;
  logic [DATA_W-1:0] dump_int_q;

  logic              cmd_q;
  logic [ENTRY_W-1:0] entry_q;
  logic              in_range_q;
  logic [DATA_W-1:0] now_q, value_q, limit_q, hold_q;
  logic [DATA_W-1:0] el_q;
  logic              dump_lt_q, dump_le_q;
  logic [DATA_W-1:0] v_q;
  logic              hit_q;

  logic              in_xfer, out_free, fin_go;
  logic              md_start, md_done, need_md;
  logic [DATA_W-1:0] md_q;
  tbl_rd_t           rd;
  tbl_wr_t           wr;
  entry_rec_t        rec, rec_new;
  logic [DATA_W:0]   dump_sum;
  logic [DATA_W-1:0] norm_new;
  logic [DATA_W:0]   norm_sum;
  alarm_state_e      st_eval;
  logic              eval_live;
  logic [1:0]        ev_d;
  logic [DATA_W-1:0] rv_d, rl_d;

  lae_table u_table (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .rd_i     (rd),
    .rd_rec_o (rec),
    .wr_i     (wr)
  );

  lae_muldiv u_muldiv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (md_start),
    .a_i     (rec.value),
    .b_i     (window_q - el_q),
    .d_i     (window_q),
    .done_o  (md_done),
    .q_o     (md_q)
  );

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      over_q     <= 1'b1;
      window_q   <= WINDOW_RESET;
      dump_int_q <= DUMP_RESET;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_OVER_MODE: over_q     <= cfg_data_i[0];
        CFG_WINDOW:    window_q   <= cfg_data_i;
        CFG_DUMP:      dump_int_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign in_xfer  = in_valid_i && in_ready_o;
  assign out_free = !out_valid_o || out_ready_i;
  assign eval_live = cmd_q && in_range_q &&
                     (rec.state == AS_ACTIVE || rec.state == AS_ALMOST);
  assign need_md  = !(el_q > window_q) && (el_q != '0);
  assign dump_sum = {1'b0, rec.dump_time} + {1'b0, dump_int_q};

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      FS_IDLE:  if (in_valid_i) state_d = FS_PREP;
      FS_PREP:  state_d = eval_live ? FS_DECAY : FS_FIN;
      FS_DECAY: state_d = need_md ? FS_WAIT : FS_CMP;
      FS_WAIT:  if (md_done) state_d = FS_CMP;
      FS_CMP:   state_d = FS_FIN;
      FS_FIN:   if (out_free) state_d = FS_IDLE;
      default:  state_d = FS_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_ready_o = (state_q == FS_IDLE);
    md_start   = (state_q == FS_DECAY) && need_md;
    fin_go     = (state_q == FS_FIN) && out_free;
    rd.en      = in_xfer;
    rd.addr    = entry_i[ADDR_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FS_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      cmd_q      <= cmd_i;
      entry_q    <= entry_i;
      in_range_q <= 32'(entry_i) < ENTRIES;
      now_q      <= now_ns_i;
      value_q    <= value_i;
      limit_q    <= limit_i;
      hold_q     <= hold_ns_i;
    end
    if (state_q == FS_PREP) begin
      el_q      <= (now_q > rec.last_time) ? now_q - rec.last_time : '0;
      dump_lt_q <= dump_sum < {1'b0, now_q};
      dump_le_q <= dump_sum <= {1'b0, now_q};
    end
    if (state_q == FS_DECAY) begin
      v_q <= (el_q > window_q) ? '0 : rec.value;
    end
    if (state_q == FS_WAIT && md_done) begin
      v_q <= md_q;
    end
    if (state_q == FS_CMP) begin
      hit_q <= over_q ? (v_q > rec.limit) : (v_q < rec.limit);
    end
  end

  // evaluate outcome for active and almost gone entries
  always_comb begin
    if (hit_q) begin
      st_eval  = AS_ACTIVE;
      norm_new = '0;
    end else if (rec.state == AS_ACTIVE) begin
      st_eval  = AS_ALMOST;
      norm_new = now_q;
    end else begin
      st_eval  = rec.state;
      norm_new = rec.norm_time;
    end
    norm_sum = {1'b0, norm_new} + {1'b0, rec.hold};
  end

  always_comb begin
    rec_new = rec;
    ev_d    = EV_NONE;
    rv_d    = '0;
    rl_d    = '0;
    if (!cmd_q) begin
      unique case (rec.state)
        AS_NEW, AS_ALMOST: ;
        AS_ACTIVE: begin
          rec_new.last_time = now_q;
          if (!dump_lt_q) begin
            rec_new.value = value_q;
          end
        end
        default: begin
          rec_new.state     = AS_NEW;
          rec_new.last_time = now_q;
          rec_new.dump_time = '0;
          rec_new.value     = value_q;
          rec_new.limit     = limit_q;
          rec_new.hold      = hold_q;
        end
      endcase
    end else begin
      unique case (rec.state)
        AS_NEW: begin
          ev_d              = EV_HIT;
          rv_d              = rec.value;
          rl_d              = rec.limit;
          rec_new.dump_time = now_q;
          rec_new.state     = AS_ACTIVE;
        end
        AS_ACTIVE, AS_ALMOST: begin
          rec_new.state     = st_eval;
          rec_new.norm_time = norm_new;
          if (st_eval == AS_ALMOST && norm_sum < {1'b0, now_q}) begin
            ev_d          = EV_NORMAL;
            rv_d          = v_q;
            rl_d          = rec.limit;
            rec_new.state = AS_GONE;
          end else if (dump_le_q) begin
            ev_d              = EV_UPDATE;
            rv_d              = v_q;
            rl_d              = rec.limit;
            rec_new.dump_time = now_q;
          end
        end
        default: ;
      endcase
    end
    if (!in_range_q) begin
      ev_d = EV_NONE;
      rv_d = '0;
      rl_d = '0;
    end
    wr.en   = fin_go && in_range_q;
    wr.addr = entry_q[ADDR_W-1:0];
    wr.rec  = rec_new;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (fin_go) begin
      out_valid_o <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fin_go) begin
      out_entry_o    <= entry_q;
      event_res_o    <= ev_d;
      report_value_o <= rv_d;
      report_limit_o <= rl_d;
    end
  end

endmodule

### src/lae_checker.sv
module lae_checker
  import lae_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_o,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input logic [1:0]        event_res_o,
  input logic [DATA_W-1:0] report_value_o,
  input logic [DATA_W-1:0] report_limit_o
);

  // a pending result holds until its transfer
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped before transfer");

  // busy after taking an item
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("item taken while busy");

  // no result appears the cycle right after an item transfer
  a_no_early: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !$rose(out_valid_o))
    else $error("result too early");

  // a result without event carries zero payload
  a_none_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && event_res_o == EV_NONE |-> report_value_o == '0 && report_limit_o == '0)
    else $error("nonzero report without event");

endmodule

bind limit_alarm_entry_table lae_checker u_lae_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_ready_o     (in_ready_o),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .event_res_o    (event_res_o),
  .report_value_o (report_value_o),
  .report_limit_o (report_limit_o)
);

### tb/tb_top.sv
module tb_top;
  import lae_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic CMD_MERGE = 1'b0;
  localparam logic CMD_EVAL  = 1'b1;
  localparam logic [DATA_W-1:0] MAX64 = '1;

  typedef struct {
    logic               cmd;
    logic [ENTRY_W-1:0] entry;
    logic [DATA_W-1:0]  now;
    logic [DATA_W-1:0]  value;
    logic [DATA_W-1:0]  limit;
    logic [DATA_W-1:0]  hold;
  } alarm_item_t;

  typedef struct {
    logic [ENTRY_W-1:0] entry;
    event_e             ev;
    logic [DATA_W-1:0]  value;
    logic [DATA_W-1:0]  limit;
  } alarm_report_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [DATA_W-1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic cmd_i = 1'b0;
  logic [ENTRY_W-1:0] entry_i = '0;
  logic [DATA_W-1:0] now_ns_i = '0;
  logic [DATA_W-1:0] value_i = '0;
  logic [DATA_W-1:0] limit_i = '0;
  logic [DATA_W-1:0] hold_ns_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [ENTRY_W-1:0] out_entry_o;
  logic [1:0] event_res_o;
  logic [DATA_W-1:0] report_value_o;
  logic [DATA_W-1:0] report_limit_o;

  limit_alarm_entry_table u_top (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // mirror of the alarm table and its settings
  alarm_state_e      tbl_state [ENTRIES];
  logic [DATA_W-1:0] tbl_last  [ENTRIES];
  logic [DATA_W-1:0] tbl_dump  [ENTRIES];
  logic [DATA_W-1:0] tbl_norm  [ENTRIES];
  logic [DATA_W-1:0] tbl_value [ENTRIES];
  logic [DATA_W-1:0] tbl_limit [ENTRIES];
  logic [DATA_W-1:0] tbl_hold  [ENTRIES];
  logic              cur_over = 1'b1;
  logic [DATA_W-1:0] cur_window = WINDOW_RESET;
  logic [DATA_W-1:0] cur_dump_ivl = DUMP_RESET;

  alarm_item_t   pending_items[$];
  alarm_report_t expected_reports[$];
  int unsigned   err_cnt = 0;
  int unsigned   items_taken = 0;
  int unsigned   event_cnt[4] = '{0, 0, 0, 0};
  logic          idle_on = 1'b0;
  logic          hold_start = 1'b0;
  int unsigned   hold_cnt = 0;

  initial for (int i = 0; i < ENTRIES; i++) tbl_state[i] = AS_ABSENT;

  // a + b against c without wrap
  function automatic int time_cmp(logic [63:0] a, logic [63:0] b, logic [63:0] c);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s > {1'b0, c}) return 1;
    if (s < {1'b0, c}) return -1;
    return 0;
  endfunction

  function automatic logic [63:0] decay_value(int unsigned e, logic [63:0] now);
    logic [63:0]  el;
    logic [127:0] prod;
    logic [127:0] quo;
    el = (now > tbl_last[e]) ? now - tbl_last[e] : '0;
    if (el > cur_window) return '0;
    if (cur_window == '0) return tbl_value[e];
    prod = {64'd0, tbl_value[e]} * {64'd0, cur_window - el};
    quo = prod / {64'd0, cur_window};
    return quo[63:0];
  endfunction

  function automatic alarm_report_t apply_item(alarm_item_t it);
    alarm_report_t r;
    alarm_state_e  st;
    int unsigned   e;
    logic [63:0]   v;
    logic          hit;
    e = 32'(it.entry);
    r.entry = it.entry;
    r.ev = EV_NONE;
    r.value = '0;
    r.limit = '0;
    st = tbl_state[e];
    if (it.cmd == CMD_MERGE) begin
      if (st == AS_ABSENT || st == AS_GONE) begin
        tbl_state[e] = AS_NEW;
        tbl_last[e] = it.now;
        tbl_dump[e] = '0;
        tbl_value[e] = it.value;
        tbl_limit[e] = it.limit;
        tbl_hold[e] = it.hold;
      end else if (st == AS_ACTIVE) begin
        tbl_last[e] = it.now;
        if (time_cmp(tbl_dump[e], cur_dump_ivl, it.now) >= 0) tbl_value[e] = it.value;
      end
    end else if (st == AS_NEW) begin
      r.ev = EV_HIT;
      r.value = tbl_value[e];
      r.limit = tbl_limit[e];
      tbl_dump[e] = it.now;
      tbl_state[e] = AS_ACTIVE;
    end else if (st == AS_ACTIVE || st == AS_ALMOST) begin
      v = decay_value(e, it.now);
      hit = cur_over ? (v > tbl_limit[e]) : (v < tbl_limit[e]);
      if (hit) begin
        st = AS_ACTIVE;
        tbl_norm[e] = '0;
      end else if (st == AS_ACTIVE) begin
        st = AS_ALMOST;
        tbl_norm[e] = it.now;
      end
      tbl_state[e] = st;
      if (st == AS_ALMOST && time_cmp(tbl_norm[e], tbl_hold[e], it.now) < 0) begin
        r.ev = EV_NORMAL;
        r.value = v;
        r.limit = tbl_limit[e];
        tbl_state[e] = AS_GONE;
      end else if (time_cmp(tbl_dump[e], cur_dump_ivl, it.now) <= 0) begin
        r.ev = EV_UPDATE;
        r.value = v;
        r.limit = tbl_limit[e];
        tbl_dump[e] = it.now;
      end
    end
    return r;
  endfunction

  // sender: one item per transfer, random gap between items when idle_on is set
  int unsigned in_gap = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    alarm_item_t nxt;
    int unsigned g;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_gap <= 0;
    end else begin
      g = in_gap;
      if (in_valid_i && in_ready_o) begin
        nxt.cmd = cmd_i; nxt.entry = entry_i; nxt.now = now_ns_i;
        nxt.value = value_i; nxt.limit = limit_i; nxt.hold = hold_ns_i;
        expected_reports.push_back(apply_item(nxt));
        items_taken++;
        g = idle_on ? $urandom_range(0, 8) : 0;
      end
      if ((!in_valid_i || in_ready_o) && g == 0 && pending_items.size() > 0) begin
        nxt = pending_items.pop_front();
        cmd_i <= nxt.cmd; entry_i <= nxt.entry; now_ns_i <= nxt.now;
        value_i <= nxt.value; limit_i <= nxt.limit; hold_ns_i <= nxt.hold;
        in_valid_i <= 1'b1;
      end else if (in_valid_i && in_ready_o) begin
        in_valid_i <= 1'b0;
      end
      in_gap <= (g != 0 && !(in_valid_i && !in_ready_o)) ? g - 1 : g;
    end
  end

  // long receiver hold-off, counted on its own
  always @(posedge clk_i) begin
    if (hold_start) hold_cnt <= 3000;
    else if (hold_cnt != 0) hold_cnt <= hold_cnt - 1;
  end

  // receiver and checker
  int unsigned out_stall = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    alarm_report_t exp_r;
    int unsigned s;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      out_stall <= 0;
    end else begin
      s = out_stall;
      if (out_valid_o && out_ready_i) begin
        if (expected_reports.size() == 0) begin
          $error("result with nothing expected: entry %0d", out_entry_o);
          err_cnt++;
        end else begin
          exp_r = expected_reports.pop_front();
          event_cnt[exp_r.ev]++;
          if (out_entry_o !== exp_r.entry) begin
            $error("out_entry expected %0d actual %0d", exp_r.entry, out_entry_o);
            err_cnt++;
          end
          if (event_res_o !== exp_r.ev) begin
            $error("event_res expected %0d actual %0d", exp_r.ev, event_res_o);
            err_cnt++;
          end
          if (report_value_o !== exp_r.value) begin
            $error("report_value expected %0d actual %0d", exp_r.value, report_value_o);
            err_cnt++;
          end
          if (report_limit_o !== exp_r.limit) begin
            $error("report_limit expected %0d actual %0d", exp_r.limit, report_limit_o);
            err_cnt++;
          end
        end
        s = idle_on ? $urandom_range(0, 8) : 0;
      end else if (s != 0) begin
        s = s - 1;
      end
      out_stall <= s;
      out_ready_i <= (s == 0) && (hold_cnt <= 1) && !hold_start;
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [63:0] pick_amount();
    case ($urandom_range(0, 4))
      0: return '0;
      1: return MAX64;
      2: return rand64();
      default: return 64'($urandom_range(0, 1000));
    endcase
  endfunction

  task automatic add_item(logic cmd, int unsigned e, logic [63:0] now, logic [63:0] v,
                          logic [63:0] l, logic [63:0] h);
    alarm_item_t it;
    it.cmd = cmd; it.entry = ENTRY_W'(e); it.now = now; it.value = v; it.limit = l;
    it.hold = h;
    pending_items.push_back(it);
  endtask

  logic [63:0] entry_clock [ENTRIES];

  task automatic add_random(int unsigned n, logic [63:0] scale);
    int unsigned e;
    int unsigned base;
    logic [63:0] step;
    logic [63:0] v;
    logic [63:0] l;
    base = $urandom_range(0, 247);
    for (int unsigned i = 0; i < n; i++) begin
      e = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255) : base + $urandom_range(0, 7);
      case ($urandom_range(0, 7))
        0: step = '0;
        1: step = rand64();
        2: step = scale;
        3: step = scale * 2;
        4: step = -64'($urandom_range(0, 100));
        default: step = (scale > 4) ? $urandom_range(1, 1000) * (scale / 1000 + 1) : 1;
      endcase
      entry_clock[e] = entry_clock[e] + step;
      v = pick_amount();
      l = $urandom_range(0, 1) ? v + $urandom_range(0, 200) - 100 : pick_amount();
      add_item($urandom_range(0, 9) < 4 ? CMD_MERGE : CMD_EVAL, e, entry_clock[e], v, l,
               $urandom_range(0, 2) == 0 ? pick_amount() : scale / 2);
    end
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [63:0] data);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    case (idx)
      CFG_OVER_MODE: cur_over = data[0];
      CFG_WINDOW:    cur_window = data;
      default:       cur_dump_ivl = data;
    endcase
  endtask

  task automatic drain();
    @(posedge clk_i);
    while (pending_items.size() != 0 || in_valid_i || expected_reports.size() != 0)
      @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic run_phase(logic ov, logic [63:0] win, logic [63:0] ivl, logic [63:0] scale,
                           logic idle, logic press);
    write_reg(CFG_OVER_MODE, {63'd0, ov});
    write_reg(CFG_WINDOW, win);
    write_reg(CFG_DUMP, ivl);
    idle_on = idle;
    add_random(300, scale);
    if (press) begin
      repeat (50) @(posedge clk_i);
      hold_start <= 1'b1;
      @(posedge clk_i);
      hold_start <= 1'b0;
    end
    drain();
  endtask

  initial begin
    for (int i = 0; i < ENTRIES; i++) entry_clock[i] = rand64() >> $urandom_range(0, 63);
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    // directed: new entry hit, refresh, decay, back to normal, restart, extremes
    add_item(CMD_EVAL, 0, 0, 0, 0, 0);
    add_item(CMD_MERGE, 0, 100, MAX64, 0, 10);
    add_item(CMD_MERGE, 0, 150, 5, 5, 5);
    add_item(CMD_EVAL, 0, 200, 0, 0, 0);
    add_item(CMD_EVAL, 0, 100, 0, 0, 0);
    add_item(CMD_MERGE, 0, 300, 7, 0, 0);
    add_item(CMD_EVAL, 0, 64'd500000300, 0, 0, 0);
    add_item(CMD_EVAL, 0, 64'd4000000000, 0, 0, 0);
    add_item(CMD_EVAL, 0, 64'd4000000001, 0, 0, 0);
    add_item(CMD_EVAL, 0, 64'd4000000020, 0, 0, 0);
    add_item(CMD_MERGE, 0, MAX64 - 5, 0, MAX64, MAX64);
    add_item(CMD_EVAL, 0, MAX64 - 5, 0, 0, 0);
    add_item(CMD_EVAL, 0, MAX64, 0, 0, 0);
    add_item(CMD_MERGE, 255, MAX64, 1000, 999, 0);
    add_item(CMD_EVAL, 255, MAX64, 0, 0, 0);
    add_item(CMD_EVAL, 255, 5, 0, 0, 0);
    add_item(CMD_MERGE, 255, 5, 3, 0, 0);
    add_item(CMD_EVAL, 255, MAX64, 0, 0, 0);
    add_item(CMD_EVAL, 255, MAX64, 0, 0, 0);
    add_item(CMD_EVAL, 128, 64'h5555_5555_5555_5555, 0, 0, 0);
    drain();
    run_phase(1'b0, 64'd1000, 64'd0, 64'd1000, 1'b1, 1'b1);
    run_phase(1'b1, 64'd1, 64'd1, 64'd1, 1'b1, 1'b0);
    run_phase(1'b0, MAX64, MAX64, 64'd1 << 62, 1'b0, 1'b0);
    run_phase(1'b1, 64'd5000, 64'd2000, 64'd5000, 1'b1, 1'b1);
    run_phase(1'b1, WINDOW_RESET, DUMP_RESET, WINDOW_RESET, 1'b1, 1'b0);
    if (expected_reports.size() != 0) begin
      $error("%0d expected results never arrived", expected_reports.size());
      err_cnt++;
    end
    $display("covered %0d items: %0d quiet, %0d limit hits, %0d updates, %0d back to normal",
             items_taken, event_cnt[0], event_cnt[1], event_cnt[2], event_cnt[3]);
    if (err_cnt == 0) begin
      $display("[limit_alarm_entry_table] OK");
    end else begin
      $display("[limit_alarm_entry_table] ERROR");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("[limit_alarm_entry_table] ERROR");
    $finish;
  end

endmodule

### sim.f
src/lae_pkg.sv
src/lae_table.sv
src/lae_muldiv.sv
src/limit_alarm_entry_table.sv
src/lae_checker.sv
tb/tb_top.sv
